/* rtl/prs_pkg.sv */
// Shared types and constants for the prime range sum block.
package prs_pkg;

   localparam int FIRST_DIVISOR = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_ADD,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic div_next;
      logic add;
      logic cand_next;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic range_empty;
      logic cand_lt2;
      logic bound_passed;
      logic rem_zero;
      logic div_last;
      logic cand_at_end;
      logic out_free;
   } status_type;

endpackage

/* rtl/prs_ctrl.sv */
// Sequencer for the range walk and trial-division loop.
module prs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  prs_pkg::status_type   status,
   output prs_pkg::cmd_type      cmd,
   output prs_pkg::state_type    state,
   output logic                  req_ready
);
   import prs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            state_in = status.range_empty ? ST_FINISH : ST_CHECK;
         end
         ST_CHECK: begin
            if (status.cand_lt2) state_in = ST_NEXT;
            else if (status.bound_passed) state_in = ST_ADD;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = status.rem_zero ? ST_NEXT : ST_CHECK;
         end
         ST_ADD: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = status.cand_at_end ? ST_FINISH : ST_CHECK;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load = req_valid;
         ST_CHECK:  cmd.div_init = !status.cand_lt2 && !status.bound_passed;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_EVAL:   cmd.div_next = !status.rem_zero;
         ST_ADD:    cmd.add = 1'b1;
         ST_NEXT:   cmd.cand_next = !status.cand_at_end;
         ST_FINISH: cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign state     = state_ff;

endmodule

/* rtl/prs_datapath.sv */
// Range registers, bit-serial remainder unit, square bound tracker and sum.
module prs_datapath #(
   parameter int VALUE_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prs_pkg::cmd_type      cmd,
   input  logic [VALUE_BITS-1:0] range_start,
   input  logic [VALUE_BITS-1:0] range_end,
   input  logic                  rsp_ready,
   output prs_pkg::status_type   status,
   output logic                  rsp_valid,
   output logic [SUM_BITS-1:0]   prime_sum
);
   import prs_pkg::*;

   localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
   localparam int DSQ_BITS = VALUE_BITS + 2;
   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] start_ff, end_ff, cand_ff, shreg_ff;
   logic [VALUE_BITS-1:0] start_in, end_in, cand_in, shreg_in;
   logic [DIV_BITS-1:0]   div_ff, div_in, rem_ff, rem_in;
   logic [DSQ_BITS-1:0]   dsq_ff, dsq_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in, out_data_ff, out_data_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DIV_BITS:0]     trial;

   // one remainder bit per cycle, MSB first
   assign trial = {rem_ff, shreg_ff[VALUE_BITS-1]};

   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      cand_in     = cand_ff;
      shreg_in    = shreg_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      dsq_in      = dsq_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      out_data_in = out_data_ff;
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         start_in = range_start;
         end_in   = range_end;
         cand_in  = range_start;
         div_in   = DIV_BITS'(FIRST_DIVISOR);
         dsq_in   = DSQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
         sum_in   = '0;
      end
      if (cmd.div_init) begin
         shreg_in = cand_ff;
         rem_in   = '0;
         cnt_in   = CNT_BITS'(VALUE_BITS);
      end
      if (cmd.div_step) begin
         shreg_in = {shreg_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - CNT_BITS'(1);
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_BITS'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_BITS'(trial);
         end
      end
      if (cmd.div_next) begin
         div_in = div_ff + DIV_BITS'(1);
         dsq_in = dsq_ff + DSQ_BITS'({div_ff, 1'b1});
      end
      if (cmd.add) begin
         sum_in = sum_ff + SUM_BITS'(cand_ff);
      end
      if (cmd.cand_next) begin
         cand_in = cand_ff + VALUE_BITS'(1);
         div_in  = DIV_BITS'(FIRST_DIVISOR);
         dsq_in  = DSQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
      end
      if (cmd.emit) begin
         out_data_in  = sum_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cand_ff      <= '0;
         div_ff       <= DIV_BITS'(FIRST_DIVISOR);
         rem_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cand_ff      <= cand_in;
         div_ff       <= div_in;
         rem_ff       <= rem_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      shreg_ff    <= shreg_in;
      dsq_ff      <= dsq_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
   end

   assign status.range_empty  = (end_ff < start_ff);
   assign status.cand_lt2     = (cand_ff < VALUE_BITS'(FIRST_DIVISOR));
   assign status.bound_passed = (dsq_ff > DSQ_BITS'(cand_ff));
   assign status.rem_zero     = (rem_ff == '0);
   assign status.div_last     = (cnt_ff == CNT_BITS'(1));
   assign status.cand_at_end  = (cand_ff == end_ff);
   assign status.out_free     = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign prime_sum = out_data_ff;

endmodule

/* rtl/prime_range_sum_top.sv */
// Top level of the prime range sum block: stream ports, controller and datapath.
// Each candidate of two or more gets bit-serial trial divisions until a divisor divides it or
//   the square of the divisor passes it; a candidate left undivided is added to the sum.
// Throughput: one request at a time; the next is taken once the result is in the output
//   register; a stalled result holds the controller in its final state.
// Reset: synchronous active-high; controller back to idle, output register empty.
module prime_range_sum_top #(
   parameter int VALUE_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // range_start, range_end
   input  logic [((2*VALUE_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // prime_sum
   output logic [((SUM_BITS+7)/8)*8-1:0]      rsp_tdata
);
   import prs_pkg::*;

   localparam int RSP_BITS = ((SUM_BITS + 7) / 8) * 8;

   cmd_type             cmd;
   status_type          status;
   state_type           state;
   logic [SUM_BITS-1:0] prime_sum;

   prs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .cmd       (cmd),
      .state     (state),
      .req_ready (req_tready)
   );

   prs_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .range_start (req_tdata[VALUE_BITS-1:0]),
      .range_end   (req_tdata[2*VALUE_BITS-1:VALUE_BITS]),
      .rsp_ready   (rsp_tready),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .prime_sum   (prime_sum)
   );

   assign rsp_tdata = RSP_BITS'(prime_sum);

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a range was still being summed");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state == ST_IDLE |-> !(cmd.add || cmd.div_step || cmd.emit))
      else $error("datapath command issued while idle");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result emitted over an undelivered result");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> req_tready && rsp_tvalid)
      else $error("result emitted without return to idle");

endmodule

/* tb/tb_prime_range_sum_top.sv */
// Testbench for prime_range_sum_top: directed and random range requests.
module tb_prime_range_sum_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W      = 24;
   localparam int SUM_W        = 48;
   localparam int REQ_W        = ((2*VALUE_W+7)/8)*8;
   localparam int RSP_W        = ((SUM_W+7)/8)*8;
   localparam int VALUE_MAX    = (1 << VALUE_W) - 1;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_COUNT = 78;
   localparam int ROW_COUNT    = 22;

   typedef struct packed {
      bit [VALUE_W-1:0] lo;
      bit [VALUE_W-1:0] hi;
      bit               known;
      bit [SUM_W-1:0]   sum;
   } range_row_type;

   // rows with known = 1 carry a hand-derived sum, the rest go through the predictor
   localparam range_row_type DIRECTED_ROWS [0:ROW_COUNT-1] = '{
      '{24'd0,        24'd0,        1'b1, 48'd0},
      '{24'd0,        24'd1,        1'b1, 48'd0},
      '{24'd1,        24'd1,        1'b1, 48'd0},
      '{24'd2,        24'd2,        1'b1, 48'd2},
      '{24'd3,        24'd3,        1'b1, 48'd3},
      '{24'd4,        24'd4,        1'b1, 48'd0},
      '{24'd0,        24'd10,       1'b1, 48'd17},
      '{24'd10,       24'd0,        1'b1, 48'd0},
      '{24'd24,       24'd28,       1'b1, 48'd0},
      '{24'd0,        24'd100,      1'b0, 48'd0},
      '{24'd2,        24'd1000,     1'b0, 48'd0},
      '{24'hFFFFFF,   24'd0,        1'b1, 48'd0},
      '{24'hFFFFFF,   24'hFFFFFF,   1'b1, 48'd0},
      '{24'hFFFFFE,   24'hFFFFFF,   1'b1, 48'd0},
      '{24'hFFFFFF,   24'hFFFFFE,   1'b1, 48'd0},
      '{24'hAAAAAA,   24'h555555,   1'b1, 48'd0},
      '{24'hFFFFFD,   24'hFFFFFD,   1'b0, 48'd0},
      '{24'h800000,   24'h800007,   1'b0, 48'd0},
      '{24'hAAAAAA,   24'hAAAAAA,   1'b0, 48'd0},
      '{24'h555555,   24'h555555,   1'b0, 48'd0},
      '{24'd4093,     24'd4099,     1'b0, 48'd0},
      '{24'd65520,    24'd65537,    1'b0, 48'd0}
   };

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // range_start, range_end
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // prime_sum
   logic [RSP_W-1:0] rsp_tdata;

   bit [SUM_W-1:0] expected_sums [$];
   int             mismatch_count = 0;
   int             burst_left     = 0;
   int             stall_phase    = 0;
   bit             free_flow      = 1'b0;

   prime_range_sum_top #(
      .VALUE_BITS(VALUE_W),
      .SUM_BITS  (SUM_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit [SUM_W-1:0] prime_sum_of_range(bit [VALUE_W-1:0] lo,
                                                         bit [VALUE_W-1:0] hi);
      bit [SUM_W-1:0] total;
      int unsigned    v;
      int unsigned    d;
      bit             prime;
      total = '0;
      if (hi < lo) return total;
      for (v = lo; v <= hi; v++) begin
         prime = (v >= prs_pkg::FIRST_DIVISOR);
         for (d = prs_pkg::FIRST_DIVISOR; prime && d * d <= v; d++) begin
            if (v % d == 0) prime = 1'b0;
         end
         if (prime) total += SUM_W'(v);
      end
      return total;
   endfunction

   // receiver: stalls while stall_phase is 9 or above, unless in a free-flow stretch
   always @(posedge clock) begin
      stall_phase <= (stall_phase == 12) ? 0 : stall_phase + 1;
      rsp_tready  <= free_flow || (stall_phase < 9);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sums.size() == 0) begin
            $error("prime_sum: unexpected result %0d", rsp_tdata[SUM_W-1:0]);
            mismatch_count++;
         end else begin
            if (rsp_tdata[SUM_W-1:0] !== expected_sums[0]) begin
               $error("prime_sum: expected %0d, got %0d", expected_sums[0],
                      rsp_tdata[SUM_W-1:0]);
               mismatch_count++;
            end
            void'(expected_sums.pop_front());
         end
      end
   end

   task automatic send_range(input bit [VALUE_W-1:0] lo, input bit [VALUE_W-1:0] hi,
                             input bit [SUM_W-1:0] sum);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({hi, lo});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_sums.push_back(sum);
   endtask

   task automatic pace_sender();
      int gap;
      if (free_flow) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 7);
      gap        = $urandom_range(1, 6);
      req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_sums.size() != 0);
   endtask

   initial begin
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    pick;
      bit [SUM_W-1:0] sum;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROW_COUNT; i++) begin
         sum = DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].sum :
               prime_sum_of_range(DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi);
         send_range(DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi, sum);
         pace_sender();
      end
      drain();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         free_flow = (i >= 30 && i < 50);
         if (i == 70) drain();
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // empty range with arbitrary bit patterns
            lo = $urandom_range(1, VALUE_MAX);
            hi = $urandom_range(0, lo - 1);
         end else if (pick < 18) begin
            // short range anywhere in the value space
            lo = $urandom_range(0, VALUE_MAX);
            hi = lo + $urandom_range(0, 2);
            if (hi > VALUE_MAX) hi = VALUE_MAX;
         end else begin
            lo = $urandom_range(0, 2047);
            hi = lo + $urandom_range(0, 15);
         end
         send_range(VALUE_W'(lo), VALUE_W'(hi),
                    prime_sum_of_range(VALUE_W'(lo), VALUE_W'(hi)));
         pace_sender();
      end
      free_flow = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
